/* rtl/core/fifo_thread_scheduler_with_mutexes_top_macros.svh */
// Assertion helpers shared by the scheduler modules.
// Each macro expects clk_i and rst_ni in the module that uses it.
`ifndef FIFO_THREAD_SCHEDULER_WITH_MUTEXES_TOP_MACROS_SVH
`define FIFO_THREAD_SCHEDULER_WITH_MUTEXES_TOP_MACROS_SVH

// Same-cycle implication
`define FTSM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scheduler check failed");

// Next-cycle implication
`define FTSM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scheduler check failed");

`endif

/* rtl/core/ftsm_pkg.sv */
package ftsm_pkg;

  // Thread pool: thread 0 is the initial thread, 1..POOL_THREADS are pooled
  localparam int POOL_THREADS = 4;
  localparam int SLOTS        = POOL_THREADS + 1;
  localparam int MUTEX_COUNT  = 4;

  localparam int THR_W  = 3;
  localparam int MIDX_W = 2;
  localparam int MCNT_W = 5;
  localparam int DATA_W = 16;
  localparam int OP_W   = 3;
  localparam int ERR_W  = 2;

  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 48;

  localparam logic [THR_W-1:0]  EMPTY_CODE = 3'd7;
  localparam logic [THR_W-1:0]  SLOT_LIM   = THR_W'(SLOTS);
  localparam logic [MCNT_W-1:0] MUTEX_LIM  = MCNT_W'(MUTEX_COUNT);

  typedef enum logic [OP_W-1:0] {
    OP_SPAWN  = 3'd0,
    OP_YIELD  = 3'd1,
    OP_LOCK   = 3'd2,
    OP_UNLOCK = 3'd3,
    OP_FINISH = 3'd4
  } op_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK       = 2'd0,
    ERR_NO_FREE  = 2'd1,
    ERR_NO_READY = 2'd2,
    ERR_INIT_FIN = 2'd3
  } err_e;

  typedef enum logic [1:0] {
    Q_FREE  = 2'd0,
    Q_READY = 2'd1,
    Q_WAIT  = 2'd2
  } qsel_e;

  typedef enum logic [2:0] {
    S_IDLE   = 3'd0,
    S_DECODE = 3'd1,
    S_PUSH   = 3'd2,
    S_POP    = 3'd3,
    S_STORE  = 3'd4,
    S_DONE   = 3'd5
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic  load_in;
    logic  push_en;
    qsel_e push_q;
    logic  push_pick;
    logic  pop_en;
    qsel_e pop_q;
    logic  run_en;
    logic  store_en;
    logic  lock_set;
    logic  lock_clr;
    logic  err_en;
    err_e  err;
    logic  out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_e  op;
    logic free_empty;
    logic ready_empty;
    logic wait_empty;
    logic locked;
    logic cur_init;
    logic m_ok;
  } stat_t;

endpackage

/* rtl/core/fifo_thread_scheduler_with_mutexes_top.sv */
// Hardware thread scheduler with a FIFO ready queue and mutex wait queues.
// Input channel s_axis: one scheduling operation per transfer. tuser holds
// the operation code (spawn, yield, lock, unlock, finish); tdata holds the
// mutex index, the entry point and the argument of a spawn.
// Output channel m_axis: one result per operation, giving the thread that
// runs afterwards with its stored entry point and argument, the first-dispatch
// flag, the thread a spawn allocated and an error code.
// An operation is taken only while the sequencer is idle. Each one runs as
// decode, an optional push step, an optional pop step and, for spawn, a store
// step, since all queues share one link table with one update per cycle.
// The result is loaded into the output register in the done step, and the next
// item is taken once the sequencer is back in idle.
// A finished result sits in an output register: the next item is accepted
// while it waits, and a stalled receiver only holds the following result.
// Reset makes thread 0 current, puts threads 1 to 4 on the free list, and
// empties the ready queue and all mutex queues with every mutex unlocked.
module fifo_thread_scheduler_with_mutexes_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // mutex_index [1:0], entry_point [17:2], spawn_argument [33:18], zero pad
  input  logic [ftsm_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // operation [2:0]
  input  logic [ftsm_pkg::OP_W-1:0]      s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // running_thread [2:0], run_entry [18:3], run_argument [34:19],
  // fresh_start [35], spawned_thread [38:36], error_code [40:39], zero pad
  output logic [ftsm_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import ftsm_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  ftsm_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .stat_i          (stat),
    .cmd_o           (cmd)
  );

  ftsm_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tdata_o (m_axis_tdata),
    .cmd_i          (cmd),
    .stat_o         (stat)
  );

endmodule

/* rtl/core/ftsm_ctrl.sv */
`include "fifo_thread_scheduler_with_mutexes_top_macros.svh"

module ftsm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid_i,
  output logic           s_axis_tready_o,
  output logic           m_axis_tvalid_o,
  input  logic           m_axis_tready_i,
  input  ftsm_pkg::stat_t stat_i,
  output ftsm_pkg::cmd_t  cmd_o
);
  import ftsm_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // State and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Sequence one operation as decode, push, pop, store and done steps
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.push_q = Q_READY;
    cmd_o.pop_q  = Q_READY;
    cmd_o.err    = ERR_OK;
    s_axis_tready_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_DONE;
        case (stat_i.op)
          OP_SPAWN: begin
            if (stat_i.free_empty) begin
              cmd_o.err_en = 1'b1;
              cmd_o.err    = ERR_NO_FREE;
            end else begin
              state_d = S_POP;
            end
          end
          OP_YIELD: state_d = S_PUSH;
          OP_LOCK: begin
            if (stat_i.m_ok) begin
              if (!stat_i.locked) begin
                cmd_o.lock_set = 1'b1;
              end else if (stat_i.ready_empty) begin
                cmd_o.err_en = 1'b1;
                cmd_o.err    = ERR_NO_READY;
              end else begin
                state_d = S_PUSH;
              end
            end
          end
          OP_UNLOCK: begin
            if (stat_i.m_ok) begin
              if (stat_i.wait_empty) begin
                cmd_o.lock_clr = 1'b1;
              end else begin
                state_d = S_PUSH;
              end
            end
          end
          OP_FINISH: begin
            if (stat_i.cur_init) begin
              cmd_o.err_en = 1'b1;
              cmd_o.err    = ERR_INIT_FIN;
            end else if (stat_i.ready_empty) begin
              cmd_o.err_en = 1'b1;
              cmd_o.err    = ERR_NO_READY;
            end else begin
              state_d = S_PUSH;
            end
          end
          default: state_d = S_DONE;
        endcase
      end
      S_PUSH: begin
        // Park the current thread on the queue the operation names
        cmd_o.push_en = 1'b1;
        case (stat_i.op)
          OP_LOCK:   cmd_o.push_q = Q_WAIT;
          OP_FINISH: cmd_o.push_q = Q_FREE;
          default:   cmd_o.push_q = Q_READY;
        endcase
        state_d = S_POP;
      end
      S_POP: begin
        // Take the head; dispatch it unless it is a fresh spawn slot
        cmd_o.pop_en = 1'b1;
        case (stat_i.op)
          OP_SPAWN:  cmd_o.pop_q = Q_FREE;
          OP_UNLOCK: cmd_o.pop_q = Q_WAIT;
          default:   cmd_o.pop_q = Q_READY;
        endcase
        cmd_o.run_en = (stat_i.op != OP_SPAWN);
        state_d = (stat_i.op == OP_SPAWN) ? S_STORE : S_DONE;
      end
      S_STORE: begin
        cmd_o.store_en  = 1'b1;
        cmd_o.push_en   = 1'b1;
        cmd_o.push_q    = Q_READY;
        cmd_o.push_pick = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        // Hold until the output register is free
        if (!out_valid_q || m_axis_tready_i) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output valid: set on load, drop on transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;

  `FTSM_ASSERT_NEXT(a_accept_decodes, s_axis_tvalid_i && s_axis_tready_o, state_q == S_DECODE)
  `FTSM_ASSERT_NOW(a_load_when_free, cmd_o.out_load, !out_valid_q || m_axis_tready_i)
  `FTSM_ASSERT_NOW(a_one_queue_op, cmd_o.pop_en, !cmd_o.push_en && !cmd_o.store_en)
  `FTSM_ASSERT_NEXT(a_stall_holds, state_q == S_DONE && out_valid_q && !m_axis_tready_i,
                    state_q == S_DONE)

endmodule

/* rtl/core/ftsm_dpath.sv */
`include "fifo_thread_scheduler_with_mutexes_top_macros.svh"

module ftsm_dpath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [ftsm_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  input  logic [ftsm_pkg::OP_W-1:0]      s_axis_tuser_i,
  output logic [ftsm_pkg::M_TDATA_W-1:0] m_axis_tdata_o,
  input  ftsm_pkg::cmd_t                 cmd_i,
  output ftsm_pkg::stat_t                stat_o
);
  import ftsm_pkg::*;

  // Latched input item
  op_e               op_q;
  logic [MIDX_W-1:0] m_q;
  logic [DATA_W-1:0] entry_in_q;
  logic [DATA_W-1:0] arg_in_q;

  // Scheduler state
  logic [THR_W-1:0] cur_q, cur_d;
  logic [THR_W-1:0] pick_q, pick_d;
  logic [THR_W-1:0] link_q [SLOTS];
  logic [THR_W-1:0] link_d [SLOTS];
  logic [THR_W-1:0] free_head_q, free_head_d, free_tail_q, free_tail_d;
  logic [THR_W-1:0] ready_head_q, ready_head_d, ready_tail_q, ready_tail_d;
  logic             locked_q [MUTEX_COUNT];
  logic             locked_d [MUTEX_COUNT];
  logic [THR_W-1:0] wait_head_q [MUTEX_COUNT];
  logic [THR_W-1:0] wait_head_d [MUTEX_COUNT];
  logic [THR_W-1:0] wait_tail_q [MUTEX_COUNT];
  logic [THR_W-1:0] wait_tail_d [MUTEX_COUNT];
  logic             never_ran_q [SLOTS];
  logic             never_ran_d [SLOTS];
  logic [DATA_W-1:0] entry_q [SLOTS];
  logic [DATA_W-1:0] arg_q [SLOTS];

  // Per-item result flags
  logic       fresh_q, fresh_d;
  logic [THR_W-1:0] spawned_q, spawned_d;
  err_e       err_q, err_d;

  logic [M_TDATA_W-1:0] out_q;

  // Queue access scratch
  logic [THR_W-1:0] push_thr, qh, qt, nh, ph, pt, pnh, pnt;

  // Latch the input fields on transfer
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q       <= op_e'(s_axis_tuser_i);
      m_q        <= s_axis_tdata_i[MIDX_W-1:0];
      entry_in_q <= s_axis_tdata_i[MIDX_W +: DATA_W];
      arg_in_q   <= s_axis_tdata_i[MIDX_W+DATA_W +: DATA_W];
    end
  end

  // Entry and argument stores, written by spawn
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_en) begin
      entry_q[pick_q] <= entry_in_q;
      arg_q[pick_q]   <= arg_in_q;
    end
  end

  // Queue state and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q        <= '0;
      pick_q       <= '0;
      free_head_q  <= THR_W'(1);
      free_tail_q  <= THR_W'(POOL_THREADS);
      ready_head_q <= EMPTY_CODE;
      ready_tail_q <= EMPTY_CODE;
      for (int i = 0; i < SLOTS; i++) begin
        link_q[i]      <= (i >= 1 && i < POOL_THREADS) ? THR_W'(i + 1) : EMPTY_CODE;
        never_ran_q[i] <= 1'b0;
      end
      for (int j = 0; j < MUTEX_COUNT; j++) begin
        locked_q[j]    <= 1'b0;
        wait_head_q[j] <= EMPTY_CODE;
        wait_tail_q[j] <= EMPTY_CODE;
      end
      fresh_q   <= 1'b0;
      spawned_q <= '0;
      err_q     <= ERR_OK;
    end else begin
      cur_q        <= cur_d;
      pick_q       <= pick_d;
      free_head_q  <= free_head_d;
      free_tail_q  <= free_tail_d;
      ready_head_q <= ready_head_d;
      ready_tail_q <= ready_tail_d;
      link_q       <= link_d;
      never_ran_q  <= never_ran_d;
      locked_q     <= locked_d;
      wait_head_q  <= wait_head_d;
      wait_tail_q  <= wait_tail_d;
      fresh_q      <= fresh_d;
      spawned_q    <= spawned_d;
      err_q        <= err_d;
    end
  end

  // Push, pop, dispatch and mutex updates
  always_comb begin
    cur_d        = cur_q;
    pick_d       = pick_q;
    link_d       = link_q;
    free_head_d  = free_head_q;
    free_tail_d  = free_tail_q;
    ready_head_d = ready_head_q;
    ready_tail_d = ready_tail_q;
    locked_d     = locked_q;
    wait_head_d  = wait_head_q;
    wait_tail_d  = wait_tail_q;
    never_ran_d  = never_ran_q;
    fresh_d      = fresh_q;
    spawned_d    = spawned_q;
    err_d        = err_q;

    push_thr = cmd_i.push_pick ? pick_q : cur_q;

    // Select the queue ends for each step
    case (cmd_i.push_q)
      Q_FREE: begin
        qh = free_head_q;
        qt = free_tail_q;
      end
      Q_WAIT: begin
        qh = wait_head_q[m_q];
        qt = wait_tail_q[m_q];
      end
      default: begin
        qh = ready_head_q;
        qt = ready_tail_q;
      end
    endcase
    case (cmd_i.pop_q)
      Q_FREE: begin
        ph = free_head_q;
        pt = free_tail_q;
      end
      Q_WAIT: begin
        ph = wait_head_q[m_q];
        pt = wait_tail_q[m_q];
      end
      default: begin
        ph = ready_head_q;
        pt = ready_tail_q;
      end
    endcase

    // Start of an item: clear the result flags
    if (cmd_i.load_in) begin
      fresh_d   = 1'b0;
      spawned_d = '0;
      err_d     = ERR_OK;
    end
    if (cmd_i.err_en) begin
      err_d = cmd_i.err;
    end

    // Append a thread at the tail
    nh = qh;
    if (cmd_i.push_en && push_thr < SLOT_LIM) begin
      link_d[push_thr] = EMPTY_CODE;
      if (qh == EMPTY_CODE || qt >= SLOT_LIM) begin
        nh = push_thr;
      end else begin
        link_d[qt] = push_thr;
      end
      case (cmd_i.push_q)
        Q_FREE: begin
          free_head_d = nh;
          free_tail_d = push_thr;
        end
        Q_WAIT: begin
          wait_head_d[m_q] = nh;
          wait_tail_d[m_q] = push_thr;
        end
        default: begin
          ready_head_d = nh;
          ready_tail_d = push_thr;
        end
      endcase
    end

    // Remove the head, optionally dispatching it
    pnh = EMPTY_CODE;
    pnt = pt;
    if (cmd_i.pop_en && ph < SLOT_LIM) begin
      pick_d = ph;
      pnh    = link_q[ph];
      if (pnh == EMPTY_CODE) begin
        pnt = EMPTY_CODE;
      end
      case (cmd_i.pop_q)
        Q_FREE: begin
          free_head_d = pnh;
          free_tail_d = pnt;
        end
        Q_WAIT: begin
          wait_head_d[m_q] = pnh;
          wait_tail_d[m_q] = pnt;
        end
        default: begin
          ready_head_d = pnh;
          ready_tail_d = pnt;
        end
      endcase
      if (cmd_i.run_en) begin
        cur_d           = ph;
        fresh_d         = never_ran_q[ph];
        never_ran_d[ph] = 1'b0;
      end
    end

    // Spawn marks the new thread as not yet run
    if (cmd_i.store_en) begin
      never_ran_d[pick_q] = 1'b1;
      spawned_d           = pick_q;
    end

    if (cmd_i.lock_set) begin
      locked_d[m_q] = 1'b1;
    end
    if (cmd_i.lock_clr) begin
      locked_d[m_q] = 1'b0;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= {7'b0, err_q, spawned_q, fresh_q,
                (cur_q == '0) ? {DATA_W{1'b0}} : arg_q[cur_q],
                (cur_q == '0) ? {DATA_W{1'b0}} : entry_q[cur_q],
                cur_q};
    end
  end

  assign m_axis_tdata_o = out_q;

  // Status towards the controller
  always_comb begin
    stat_o.op          = op_q;
    stat_o.m_ok        = ({{(MCNT_W-MIDX_W){1'b0}}, m_q} < MUTEX_LIM);
    stat_o.free_empty  = (free_head_q == EMPTY_CODE);
    stat_o.ready_empty = (ready_head_q == EMPTY_CODE);
    stat_o.wait_empty  = (wait_head_q[m_q] == EMPTY_CODE);
    stat_o.locked      = locked_q[m_q];
    stat_o.cur_init    = (cur_q == '0);
  end

  `FTSM_ASSERT_NOW(a_ready_ends, 1'b1,
                   (ready_head_q == EMPTY_CODE) == (ready_tail_q == EMPTY_CODE))
  `FTSM_ASSERT_NOW(a_free_ends, 1'b1,
                   (free_head_q == EMPTY_CODE) == (free_tail_q == EMPTY_CODE))
  `FTSM_ASSERT_NOW(a_pop_nonempty, cmd_i.pop_en && cmd_i.pop_q == Q_READY,
                   ready_head_q != EMPTY_CODE)

endmodule
